@@ rtl/suart_pkg.sv @@
// shared types and codes for the soft uart transceiver
// no dependencies
package suart_pkg;

    // event operation codes
    localparam logic [2:0] OP_RX_START = 3'd0;
    localparam logic [2:0] OP_RX_SAMPLE = 3'd1;
    localparam logic [2:0] OP_TX_TICK = 3'd2;
    localparam logic [2:0] OP_TX_PUSH = 3'd3;
    localparam logic [2:0] OP_RX_POP = 3'd4;

    // receive event codes
    localparam logic [2:0] EV_NONE = 3'd0;
    localparam logic [2:0] EV_STORED = 3'd1;
    localparam logic [2:0] EV_FALSE_START = 3'd2;
    localparam logic [2:0] EV_BAD_STOP = 3'd3;
    localparam logic [2:0] EV_OVERRUN = 3'd4;

    // index of the last data bit in a frame
    localparam logic [2:0] LAST_BIT = 3'd7;

    // serial phase, shared by receiver and transmitter
    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_ARMED = 4'b0010,
        PH_START = 4'b0100,
        PH_DATA  = 4'b1000
    } t_phase;

    // decoded command, one bit set per accepted transfer at most
    typedef struct packed {
        logic rx_start;
        logic rx_sample;
        logic tx_tick;
        logic tx_push;
        logic rx_pop;
    } t_cmd;

    // receiver results of one event
    typedef struct packed {
        logic [2:0] rx_event;
        logic       pop_ok;
        logic       not_empty;
    } t_rx_status;

endpackage

@@ rtl/suart_ram.sv @@
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
module suart_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/suart_rx.sv @@
// receiver: start check, lsb-first shift, stop check and receive fifo
// depends on suart_pkg and suart_ram
module suart_rx #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  suart_pkg::t_cmd      i_cmd,
    input  logic                 i_level,
    output suart_pkg::t_rx_status o_status,
    output logic [7:0]           o_pop_data
);
    import suart_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam logic [PW-1:0] PTR_LAST = PW'(FIFO_DEPTH - 1);

    t_phase        r_phase, n_phase;
    logic [2:0]    r_cnt, n_cnt;
    logic [7:0]    r_shift, n_shift;
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [PW-1:0] wptr_inc, rptr_inc;
    logic          wr_en, rd_en, full, empty;
    logic [2:0]    rx_event;
    logic          pop_ok;

    assign wptr_inc = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
    assign rptr_inc = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
    assign full     = (wptr_inc == r_rptr);
    assign empty    = (r_wptr == r_rptr);

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_shift  = r_shift;
        n_wptr   = r_wptr;
        n_rptr   = r_rptr;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        rx_event = EV_NONE;
        pop_ok   = 1'b0;

        if (i_cmd.rx_start && r_phase == PH_IDLE) begin
            n_phase = PH_ARMED;
        end

        if (i_cmd.rx_sample) begin
            unique case (r_phase)
                PH_IDLE: begin
                end
                PH_ARMED: begin
                    // start bit must still be low at mid-bit
                    if (i_level) begin
                        n_phase  = PH_IDLE;
                        rx_event = EV_FALSE_START;
                    end else begin
                        n_phase = PH_START;
                    end
                end
                PH_START: begin
                    n_phase = PH_DATA;
                    n_cnt   = '0;
                    n_shift = {i_level, r_shift[7:1]};
                end
                PH_DATA: begin
                    if (r_cnt == LAST_BIT) begin
                        // stop bit
                        n_phase = PH_IDLE;
                        if (!i_level) begin
                            rx_event = EV_BAD_STOP;
                        end else if (full) begin
                            rx_event = EV_OVERRUN;
                        end else begin
                            wr_en    = 1'b1;
                            n_wptr   = wptr_inc;
                            rx_event = EV_STORED;
                        end
                    end else begin
                        n_cnt   = r_cnt + 1'b1;
                        n_shift = {i_level, r_shift[7:1]};
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        if (i_cmd.rx_pop && !empty) begin
            rd_en  = 1'b1;
            pop_ok = 1'b1;
            n_rptr = rptr_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_shift <= '0;
            r_wptr  <= '0;
            r_rptr  <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_shift <= n_shift;
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
        end
    end

    suart_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wptr),
        .i_wr_data (r_shift),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rptr),
        .o_rd_data (o_pop_data)
    );

    // not_empty comes from the registered pointers, so it reflects the last transfer
    assign o_status.rx_event  = rx_event;
    assign o_status.pop_ok    = pop_ok;
    assign o_status.not_empty = !empty;

endmodule

@@ rtl/suart_tx.sv @@
// transmitter: transmit fifo, frame sequencer and line register
// depends on suart_pkg and suart_ram
module suart_tx #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  suart_pkg::t_cmd i_cmd,
    input  logic [7:0]      i_byte,
    output logic            o_push_ok,
    output logic            o_line
);
    import suart_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam logic [PW-1:0] PTR_LAST = PW'(FIFO_DEPTH - 1);

    t_phase        r_phase, n_phase;
    logic [2:0]    r_cnt, n_cnt;
    logic [7:0]    r_shift, n_shift;
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic          r_line, n_line;
    logic          r_load, n_load;
    logic [PW-1:0] wptr_inc, rptr_inc;
    logic [7:0]    rd_data;
    logic          wr_en, push_ok;

    assign wptr_inc = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
    assign rptr_inc = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_line  = r_line;
        n_load  = 1'b0;
        wr_en   = 1'b0;
        push_ok = 1'b0;
        // load-tick byte enters r_shift via ram read reg, before bit 0 goes out
        n_shift = r_load ? rd_data : r_shift;

        if (i_cmd.tx_tick) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (r_rptr != r_wptr) begin
                        n_load  = 1'b1;
                        n_rptr  = rptr_inc;
                        n_phase = PH_ARMED;
                    end
                end
                PH_ARMED: begin
                    n_line  = 1'b0;
                    n_phase = PH_START;
                end
                PH_START: begin
                    n_line  = r_shift[0];
                    n_shift = {1'b0, r_shift[7:1]};
                    n_cnt   = '0;
                    n_phase = PH_DATA;
                end
                PH_DATA: begin
                    if (r_cnt == LAST_BIT) begin
                        n_line  = 1'b1;
                        n_phase = PH_IDLE;
                    end else begin
                        n_line  = r_shift[0];
                        n_shift = {1'b0, r_shift[7:1]};
                        n_cnt   = r_cnt + 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        if (i_cmd.tx_push && wptr_inc != r_rptr) begin
            wr_en   = 1'b1;
            push_ok = 1'b1;
            n_wptr  = wptr_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_shift <= '0;
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_line  <= 1'b1;
            r_load  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_shift <= n_shift;
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_line  <= n_line;
            r_load  <= n_load;
        end
    end

    suart_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wptr),
        .i_wr_data (i_byte),
        .i_rd_en   (n_load),
        .i_rd_addr (r_rptr),
        .o_rd_data (rd_data)
    );

    assign o_push_ok = push_ok;
    assign o_line    = r_line;

endmodule

@@ rtl/soft_uart_transceiver_fifo.sv @@
// top level of the bit-timed 8n1 uart transceiver with receive and transmit fifos
// depends on suart_pkg, suart_rx, suart_tx and suart_ram
//
// One event is taken per clock: rx start edge, rx mid-bit sample, tx bit tick,
// push of a tx byte or pop of an rx byte. Every accepted transfer yields exactly
// one result in the next cycle, held in an output register; the next event is
// accepted in the same cycle the result leaves, so the sustained rate is one
// event per clock and only a stalled result holds the input. Both fifos sit in
// synchronous rams with a registered read; a popped byte is taken
// straight from the rx ram read port, and a byte loaded for transmission reaches
// the shift register through that read register, ahead of its first data bit.
// Each fifo holds FIFO_DEPTH-1 bytes. A byte completed while the rx fifo is full
// is dropped and reported as an overrun; a push to a full tx fifo is refused.
// No clearing pass is needed after reset.
module soft_uart_transceiver_fifo #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // event channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_operation,
    input  logic       i_rx_level,
    input  logic [7:0] i_tx_byte,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_tx_line,
    output logic [7:0] o_rx_byte,
    output logic       o_rx_byte_valid,
    output logic       o_rx_not_empty,
    output logic       o_push_accepted,
    output logic [2:0] o_rx_event
);
    import suart_pkg::*;

    t_cmd       cmd;
    t_rx_status rx_status;
    logic [7:0] pop_data;
    logic       push_ok;
    logic       tx_line;
    logic       accept;

    // output register bank
    logic       r_out_valid;
    logic       r_pop_ok;
    logic       r_push_ok;
    logic [2:0] r_rx_event;

    // hold the input only while a result waits and the far side stalls
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    // decode the operation; nothing fires without a transfer
    always_comb begin
        cmd = '0;
        if (accept) begin
            unique case (i_operation)
                OP_RX_START:  cmd.rx_start  = 1'b1;
                OP_RX_SAMPLE: cmd.rx_sample = 1'b1;
                OP_TX_TICK:   cmd.tx_tick   = 1'b1;
                OP_TX_PUSH:   cmd.tx_push   = 1'b1;
                OP_RX_POP:    cmd.rx_pop    = 1'b1;
                default: begin
                    // unused codes only report status
                end
            endcase
        end
    end

    suart_rx #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_rx (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_level    (i_rx_level),
        .o_status   (rx_status),
        .o_pop_data (pop_data)
    );

    suart_tx #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_tx (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_byte    (i_tx_byte),
        .o_push_ok (push_ok),
        .o_line    (tx_line)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result fields of the accepted event
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pop_ok   <= rx_status.pop_ok;
            r_push_ok  <= push_ok;
            r_rx_event <= rx_status.rx_event;
        end
    end

    // line level and fifo status change only on a transfer, so they are
    // read from state directly; the ram read port holds until the next pop
    assign o_out_valid     = r_out_valid;
    assign o_tx_line       = tx_line;
    assign o_rx_byte       = r_pop_ok ? pop_data : 8'h00;
    assign o_rx_byte_valid = r_pop_ok;
    assign o_rx_not_empty  = rx_status.not_empty;
    assign o_push_accepted = r_push_ok;
    assign o_rx_event      = r_rx_event;

endmodule

@@ test/tb_soft_uart_transceiver_fifo.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the soft uart transceiver with rx and tx fifos
// depends on suart_pkg and soft_uart_transceiver_fifo; events are predicted in-line
module tb_soft_uart_transceiver_fifo;
    import suart_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PER_PHASE = 325;
    localparam int SETTLE_CYCLES = 20;

    // serial bit position, same numbering for the receiver and the transmitter
    localparam logic [3:0] SER_IDLE = 4'd0;
    localparam logic [3:0] SER_ARMED = 4'd1;
    localparam logic [3:0] SER_START = 4'd2;
    localparam logic [3:0] SER_BIT0 = 4'd3;
    localparam logic [3:0] SER_BIT7 = 4'd10;

    // one event on the input channel
    typedef struct packed {
        logic [2:0] op;
        logic       level;
        logic [7:0] data;
    } t_uart_event;

    // one result on the output channel
    typedef struct packed {
        logic       tx_line;
        logic [7:0] rx_byte;
        logic       rx_byte_valid;
        logic       rx_not_empty;
        logic       push_accepted;
        logic [2:0] rx_event;
    } t_uart_status;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [2:0] i_operation = '0;
    logic       i_rx_level = 1'b0;
    logic [7:0] i_tx_byte = '0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_tx_line;
    logic [7:0] o_rx_byte;
    logic       o_rx_byte_valid;
    logic       o_rx_not_empty;
    logic       o_push_accepted;
    logic [2:0] o_rx_event;

    t_uart_event  queued_events[$];
    t_uart_status predicted_status[$];
    t_uart_event  next_event;
    t_uart_status seen_status;
    t_uart_status want_status;

    int errors = 0;
    int cycle_count = 0;
    int events_queued = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;

    // shadow state of the transceiver; 4-bit pointers wrap at the fifo depth of 16
    logic [3:0] rx_phase = SER_IDLE;
    logic [7:0] rx_shift = '0;
    logic [7:0] rx_mem[16];
    logic [3:0] rx_wr = '0;
    logic [3:0] rx_rd = '0;
    logic [3:0] tx_phase = SER_IDLE;
    logic [7:0] tx_shift = '0;
    logic [7:0] tx_mem[16];
    logic [3:0] tx_wr = '0;
    logic [3:0] tx_rd = '0;
    logic       tx_level = 1'b1;

    soft_uart_transceiver_fifo #(
        .FIFO_DEPTH(16)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_rx_level     (i_rx_level),
        .i_tx_byte      (i_tx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_tx_line      (o_tx_line),
        .o_rx_byte      (o_rx_byte),
        .o_rx_byte_valid(o_rx_byte_valid),
        .o_rx_not_empty (o_rx_not_empty),
        .o_push_accepted(o_push_accepted),
        .o_rx_event     (o_rx_event)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // apply one event to the shadow state and return the status it should report
    function automatic t_uart_status uart_step(t_uart_event ev);
        t_uart_status r;
        logic [3:0]   nw;
        r = '0;
        case (ev.op)
            OP_RX_START: begin
                // a start edge only arms an idle receiver
                if (rx_phase == SER_IDLE) rx_phase = SER_ARMED;
            end
            OP_RX_SAMPLE: begin
                if (rx_phase != SER_IDLE) begin
                    rx_phase = rx_phase + 4'd1;
                    if (rx_phase == SER_START) begin
                        // start bit must still be low, else it was a glitch
                        if (ev.level) begin
                            rx_phase = SER_IDLE;
                            r.rx_event = EV_FALSE_START;
                        end
                    end else if (rx_phase >= SER_BIT0 && rx_phase <= SER_BIT7) begin
                        // lsb first, each new bit enters at the top
                        rx_shift = {ev.level, rx_shift[7:1]};
                    end else begin
                        // stop bit
                        if (!ev.level) begin
                            r.rx_event = EV_BAD_STOP;
                        end else begin
                            nw = rx_wr + 4'd1;
                            if (nw == rx_rd) begin
                                r.rx_event = EV_OVERRUN;
                            end else begin
                                rx_mem[rx_wr] = rx_shift;
                                rx_wr = nw;
                                r.rx_event = EV_STORED;
                            end
                        end
                        rx_phase = SER_IDLE;
                    end
                end
            end
            OP_TX_TICK: begin
                if (tx_phase == SER_IDLE) begin
                    // idle tick loads the next byte, line stays high
                    if (tx_rd != tx_wr) begin
                        tx_shift = tx_mem[tx_rd];
                        tx_rd = tx_rd + 4'd1;
                        tx_phase = SER_ARMED;
                    end
                end else begin
                    tx_phase = tx_phase + 4'd1;
                    if (tx_phase == SER_START) begin
                        tx_level = 1'b0;
                    end else if (tx_phase >= SER_BIT0 && tx_phase <= SER_BIT7) begin
                        tx_level = tx_shift[0];
                        tx_shift = {1'b0, tx_shift[7:1]};
                    end else begin
                        tx_level = 1'b1;
                        tx_phase = SER_IDLE;
                    end
                end
            end
            OP_TX_PUSH: begin
                // full when one slot is left, so 15 bytes at most
                nw = tx_wr + 4'd1;
                if (nw != tx_rd) begin
                    tx_mem[tx_wr] = ev.data;
                    tx_wr = nw;
                    r.push_accepted = 1'b1;
                end
            end
            OP_RX_POP: begin
                if (rx_rd != rx_wr) begin
                    r.rx_byte = rx_mem[rx_rd];
                    r.rx_byte_valid = 1'b1;
                    rx_rd = rx_rd + 4'd1;
                end
            end
            default: begin
                // unused codes only report status
            end
        endcase
        r.tx_line = tx_level;
        r.rx_not_empty = (rx_rd != rx_wr);
        return r;
    endfunction

    // driver: presents queued events, holds the payload while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predicted_status.push_back(uart_step({i_operation, i_rx_level, i_tx_byte}));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (queued_events.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    next_event = queued_events.pop_front();
                    i_in_valid <= 1'b1;
                    i_operation <= next_event.op;
                    i_rx_level <= next_event.level;
                    i_tx_byte <= next_event.data;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    // monitor: compares each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                seen_status = {o_tx_line, o_rx_byte, o_rx_byte_valid, o_rx_not_empty,
                               o_push_accepted, o_rx_event};
                if (predicted_status.size() == 0) begin
                    $error("result transfer with no prediction pending");
                    errors++;
                end else begin
                    want_status = predicted_status.pop_front();
                    check_field("tx_line", int'(want_status.tx_line),
                                int'(seen_status.tx_line));
                    check_field("rx_byte", int'(want_status.rx_byte),
                                int'(seen_status.rx_byte));
                    check_field("rx_byte_valid", int'(want_status.rx_byte_valid),
                                int'(seen_status.rx_byte_valid));
                    check_field("rx_not_empty", int'(want_status.rx_not_empty),
                                int'(seen_status.rx_not_empty));
                    check_field("push_accepted", int'(want_status.push_accepted),
                                int'(seen_status.push_accepted));
                    check_field("rx_event", int'(want_status.rx_event),
                                int'(seen_status.rx_event));
                end
            end
            i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("soft_uart_transceiver_fifo test failed");
            $finish;
        end
    end

    task automatic queue_event(logic [2:0] op, logic level, logic [7:0] data);
        queued_events.push_back(t_uart_event'{op: op, level: level, data: data});
        events_queued++;
    endtask

    // unrelated traffic slipped into an rx frame; none of it disturbs the receiver
    task automatic maybe_interleave();
        logic [2:0] op;
        if ($urandom_range(99) < 15) begin
            case ($urandom_range(3))
                0: op = OP_TX_TICK;
                1: op = OP_TX_PUSH;
                2: op = OP_RX_POP;
                default: op = OP_RX_START;
            endcase
            queue_event(op, 1'($urandom_range(1)), 8'($urandom_range(255)));
        end
    endtask

    // start edge, start bit, 8 data bits lsb first, stop bit
    task automatic queue_rx_frame(logic [7:0] data, logic stop_level);
        queue_event(OP_RX_START, 1'($urandom_range(1)), 8'($urandom_range(255)));
        maybe_interleave();
        queue_event(OP_RX_SAMPLE, 1'b0, 8'($urandom_range(255)));
        for (int i = 0; i < 8; i++) begin
            maybe_interleave();
            queue_event(OP_RX_SAMPLE, data[i], 8'($urandom_range(255)));
        end
        maybe_interleave();
        queue_event(OP_RX_SAMPLE, stop_level, 8'($urandom_range(255)));
    endtask

    task automatic queue_burst(logic [2:0] op, int count);
        for (int i = 0; i < count; i++) begin
            queue_event(op, 1'($urandom_range(1)), 8'($urandom_range(255)));
        end
    endtask

    // mostly well-formed frames and fifo traffic, some noise and broken frames
    task automatic queue_random_traffic(int count);
        int stop_at;
        int pick;
        stop_at = events_queued + count;
        while (events_queued < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                queue_rx_frame(8'($urandom_range(255)), $urandom_range(99) < 85);
            end else if (pick < 36) begin
                // glitch: line already back high at the start bit
                queue_event(OP_RX_START, 1'($urandom_range(1)), 8'($urandom_range(255)));
                queue_event(OP_RX_SAMPLE, 1'b1, 8'($urandom_range(255)));
            end else if (pick < 42) begin
                // truncated frame or stray samples
                if ($urandom_range(1)) begin
                    queue_event(OP_RX_START, 1'($urandom_range(1)),
                                8'($urandom_range(255)));
                end
                queue_burst(OP_RX_SAMPLE, $urandom_range(6, 1));
            end else if (pick < 60) begin
                queue_burst(OP_TX_PUSH, $urandom_range(4, 1));
            end else if (pick < 78) begin
                queue_burst(OP_TX_TICK, $urandom_range(24, 1));
            end else if (pick < 90) begin
                queue_burst(OP_RX_POP, $urandom_range(4, 1));
            end else if (pick < 94) begin
                for (int i = $urandom_range(3, 1); i > 0; i--) begin
                    queue_event(3'($urandom_range(7)), 1'($urandom_range(1)),
                                8'($urandom_range(255)));
                end
            end else if (pick < 96) begin
                // more good frames than the rx fifo holds, aiming at an overrun
                for (int i = 0; i < 16; i++) begin
                    queue_rx_frame(8'($urandom_range(255)), 1'b1);
                end
            end else if (pick < 97) begin
                queue_burst(OP_RX_POP, 17);
            end else if (pick < 99) begin
                // fill the tx fifo past capacity so pushes get refused
                queue_burst(OP_TX_PUSH, 17);
            end else begin
                queue_burst(OP_TX_TICK, 180);
            end
        end
    endtask

    // sender holds off until every predicted result has been checked
    task automatic wait_all_done();
        while (queued_events.size() != 0 || i_in_valid || predicted_status.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        int idle_plan[4];
        int stall_plan[4];
        idle_plan = '{0, 50, 0, 35};
        stall_plan = '{0, 0, 50, 35};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty pop, unused codes, idle sample and tick, glitch,
        // push extremes, a frame with a low stop bit and a stray start edge
        queue_event(OP_RX_POP, 1'b0, 8'h00);
        queue_event(3'd5, 1'b1, 8'hFF);
        queue_event(3'd6, 1'b0, 8'hFF);
        queue_event(3'd7, 1'b1, 8'h00);
        queue_event(OP_RX_SAMPLE, 1'b1, 8'h00);
        queue_event(OP_TX_TICK, 1'b0, 8'h00);
        queue_event(OP_RX_START, 1'b0, 8'h00);
        queue_event(OP_RX_SAMPLE, 1'b1, 8'hFF);
        queue_event(OP_TX_PUSH, 1'b0, 8'hFF);
        queue_event(OP_TX_PUSH, 1'b1, 8'h00);
        queue_event(OP_RX_START, 1'b0, 8'h00);
        queue_event(OP_RX_SAMPLE, 1'b0, 8'h00);
        queue_event(OP_RX_START, 1'b1, 8'h00);
        for (int i = 0; i < 8; i++) begin
            queue_event(OP_RX_SAMPLE, i[0], 8'h00);
        end
        queue_event(OP_RX_SAMPLE, 1'b0, 8'h00);
        queue_event(OP_RX_POP, 1'b0, 8'h00);

        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct = idle_plan[ph];
            receiver_stall_pct = stall_plan[ph];
            queue_random_traffic(RANDOM_PER_PHASE);
            wait_all_done();
        end

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (predicted_status.size() != 0) begin
            $error("%0d predicted results never arrived", predicted_status.size());
            errors++;
        end
        if (errors == 0) begin
            $display("soft_uart_transceiver_fifo test passed");
        end else begin
            $display("soft_uart_transceiver_fifo test failed");
        end
        $finish;
    end

endmodule
